// ----- hdl/derb_pkg.sv -----
package derb_pkg;

  // Field and register widths.
  localparam int LANES       = 2;
  localparam int TICK_W      = 16;
  localparam int SCALE_W     = 16;
  localparam int PERIOD_W    = 16;
  localparam int RANGE_W     = 15;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int PROD_W      = TICK_W + SCALE_W;

  // Lane numbering inside the two-sensor arrays.
  localparam int LANE_LEFT  = 0;
  localparam int LANE_RIGHT = 1;

  typedef logic [TICK_W-1:0]   tick_t;
  typedef logic [SCALE_W-1:0]  scale_t;
  typedef logic [PERIOD_W-1:0] period_t;
  typedef logic [RANGE_W-1:0]  range_t;
  typedef logic [PROD_W-1:0]   prod_t;

  // Configuration register map.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DISTANCE_SCALE = 3'd0,
    REG_FAR_PERIOD     = 3'd1,
    REG_MID_PERIOD     = 3'd2,
    REG_NEAR_PERIOD    = 3'd3,
    REG_CONTACT_PERIOD = 3'd4
  } cfg_reg_t;

  // Reset values of the configuration registers.
  localparam scale_t  SCALE_RESET          = 16'd17505;
  localparam period_t FAR_PERIOD_RESET     = 16'd188;
  localparam period_t MID_PERIOD_RESET     = 16'd38;
  localparam period_t NEAR_PERIOD_RESET    = 16'd8;
  localparam period_t CONTACT_PERIOD_RESET = 16'd5;

  // Upper edges of the beeper distance bands, in centimetres.
  localparam range_t FAR_LIMIT     = 15'd100;
  localparam range_t MID_LIMIT     = 15'd50;
  localparam range_t NEAR_LIMIT    = 15'd10;
  localparam range_t CONTACT_LIMIT = 15'd2;

  // Largest distance that fits the range field.
  localparam range_t RANGE_MAX = '1;

  // Sensor cycle phases.
  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_WAIT = 3'b010,
    PH_MEAS = 3'b100
  } phase_t;

endpackage

// ----- hdl/derb_if.sv -----
// Sample channel: the two sampled echo levels of one tick.
interface derb_sample_if import derb_pkg::*; ();
  logic valid;
  logic ready;
  logic echo_left;
  logic echo_right;

  modport source (output valid, output echo_left, output echo_right, input ready);
  modport sink   (input valid, input echo_left, input echo_right, output ready);
endinterface

// Result channel: one word per tick.
interface derb_result_if import derb_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   trig_left;
  logic   trig_right;
  logic   beep;
  range_t range_left;
  range_t range_right;
  logic   fresh_left;
  logic   fresh_right;

  modport source (
    output valid, output trig_left, output trig_right, output beep,
    output range_left, output range_right, output fresh_left, output fresh_right,
    input ready
  );
  modport sink (
    input valid, input trig_left, input trig_right, input beep,
    input range_left, input range_right, input fresh_left, input fresh_right,
    output ready
  );
endinterface

// Configuration write channel.
interface derb_cfg_if import derb_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/dual_echo_ranger_with_beeper_top.sv -----
// Two-sensor ultrasonic ranger with a proximity beeper. Each word on the sample
// channel is one time tick carrying both echo levels; each tick gives exactly one
// result word with the trigger pulses, the beep pulse, both latest distances and
// their update flags. The block takes one tick per clock cycle while the result
// channel does not stall: the tick is held in an input register, and the sensor
// phases, the ticks-to-centimetres multiply, the nearest-distance band selection
// and the beep counter are all worked out from the held tick into the result
// register. Both registers sit in one ready chain, so while a result waits one
// more tick can still be taken into the input register; the sample channel
// stalls only once both registers are full. Configuration writes are accepted
// at any time and must only be made while no tick is in flight; an unknown
// register index is ignored.
module dual_echo_ranger_with_beeper_top import derb_pkg::*; (
  input logic           clk,
  input logic           rst,
  derb_sample_if.sink   samples,
  derb_result_if.source results,
  derb_cfg_if.sink      cfg
);

  // Configuration registers.
  scale_t  distance_scale;
  period_t far_period;
  period_t mid_period;
  period_t near_period;
  period_t contact_period;

  // Input register.
  logic             stg_valid;
  logic [LANES-1:0] stg_echo;

  // Sensor and beeper state.
  phase_t  phase [LANES];
  tick_t   ticks [LANES];
  range_t  distance [LANES];
  tick_t   beep_ticks;

  // Result register.
  logic             out_valid;
  logic [LANES-1:0] out_trigger;
  logic [LANES-1:0] out_fresh;
  logic             out_beep;
  range_t           out_range [LANES];

  // Next-state values.
  phase_t           phase_next [LANES];
  tick_t            ticks_next [LANES];
  range_t           distance_next [LANES];
  prod_t            product [LANES];
  logic [LANES-1:0] trigger_next;
  logic [LANES-1:0] fresh_next;
  tick_t            beep_ticks_next;
  logic             beep_next;
  tick_t            beep_inc;
  range_t           nearest;
  period_t          period;
  logic             banded;
  logic             advance;

  // The held tick moves on when the result register is free or being emptied.
  assign advance       = stg_valid && (!out_valid || results.ready);
  assign samples.ready = !stg_valid || advance;
  assign cfg.ready     = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      distance_scale <= SCALE_RESET;
      far_period     <= FAR_PERIOD_RESET;
      mid_period     <= MID_PERIOD_RESET;
      near_period    <= NEAR_PERIOD_RESET;
      contact_period <= CONTACT_PERIOD_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg_reg_t'(cfg.index))
        REG_DISTANCE_SCALE: distance_scale <= cfg.data;
        REG_FAR_PERIOD:     far_period     <= cfg.data;
        REG_MID_PERIOD:     mid_period     <= cfg.data;
        REG_NEAR_PERIOD:    near_period    <= cfg.data;
        REG_CONTACT_PERIOD: contact_period <= cfg.data;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (samples.ready) begin
      stg_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      stg_echo[LANE_LEFT]  <= samples.echo_left;
      stg_echo[LANE_RIGHT] <= samples.echo_right;
    end
  end

  // Per-sensor cycle: trigger in idle, restart the count at one on the echo rising edge,
  // and convert the count to centimetres on the falling edge.
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      phase_next[i]    = phase[i];
      ticks_next[i]    = ticks[i] + TICK_W'(1);
      distance_next[i] = distance[i];
      trigger_next[i]  = 1'b0;
      fresh_next[i]    = 1'b0;
      product[i]       = PROD_W'(ticks[i]) * PROD_W'(distance_scale);
      case (phase[i])
        PH_WAIT: begin
          if (stg_echo[i]) begin
            ticks_next[i] = TICK_W'(1);
            phase_next[i] = PH_MEAS;
          end
        end
        PH_MEAS: begin
          if (!stg_echo[i]) begin
            if (|product[i][PROD_W-1:TICK_W+RANGE_W]) begin
              distance_next[i] = RANGE_MAX;
            end else begin
              distance_next[i] = product[i][TICK_W+RANGE_W-1:TICK_W];
            end
            fresh_next[i] = 1'b1;
            phase_next[i] = PH_IDLE;
          end
        end
        default: begin
          trigger_next[i] = 1'b1;
          phase_next[i]   = PH_WAIT;
        end
      endcase
    end
  end

  // Beeper: pick the period from the band of the nearer updated distance.
  always_comb begin
    beep_inc = beep_ticks + TICK_W'(1);
    if (distance_next[LANE_LEFT] < distance_next[LANE_RIGHT]) begin
      nearest = distance_next[LANE_LEFT];
    end else begin
      nearest = distance_next[LANE_RIGHT];
    end
    banded = 1'b1;
    period = '0;
    if (nearest > FAR_LIMIT) begin
      banded = 1'b0;
    end else if (nearest > MID_LIMIT) begin
      period = far_period;
    end else if (nearest > NEAR_LIMIT) begin
      period = mid_period;
    end else if (nearest > CONTACT_LIMIT) begin
      period = near_period;
    end else begin
      period = contact_period;
    end
    if (banded && beep_inc == period) begin
      beep_ticks_next = '0;
      beep_next       = 1'b1;
    end else begin
      beep_ticks_next = beep_inc;
      beep_next       = 1'b0;
    end
  end

  // State update, once per tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LANES; i++) begin
        phase[i]    <= PH_IDLE;
        ticks[i]    <= '0;
        distance[i] <= '0;
      end
      beep_ticks <= '0;
    end else if (advance) begin
      for (int i = 0; i < LANES; i++) begin
        phase[i]    <= phase_next[i];
        ticks[i]    <= ticks_next[i];
        distance[i] <= distance_next[i];
      end
      beep_ticks <= beep_ticks_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_trigger <= trigger_next;
      out_fresh   <= fresh_next;
      out_beep    <= beep_next;
      for (int i = 0; i < LANES; i++) begin
        out_range[i] <= distance_next[i];
      end
    end
  end

  assign results.valid       = out_valid;
  assign results.trig_left   = out_trigger[LANE_LEFT];
  assign results.trig_right  = out_trigger[LANE_RIGHT];
  assign results.beep        = out_beep;
  assign results.range_left  = out_range[LANE_LEFT];
  assign results.range_right = out_range[LANE_RIGHT];
  assign results.fresh_left  = out_fresh[LANE_LEFT];
  assign results.fresh_right = out_fresh[LANE_RIGHT];

  // A sensor never triggers and completes a measurement in the same tick.
  a_trigger_fresh_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_trigger[LANE_LEFT] && out_fresh[LANE_LEFT]) &&
                  !(out_trigger[LANE_RIGHT] && out_fresh[LANE_RIGHT]))
    else $error("trigger and fresh flag set together");

  // A beep restarts the beep counter.
  a_beep_clears_counter: assert property (@(posedge clk) disable iff (rst)
    (advance && beep_next) |=> (beep_ticks == '0))
    else $error("beep counter not cleared after a beep");

  // State only moves when a tick is processed.
  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(beep_ticks) && $stable(distance[LANE_LEFT]) &&
                 $stable(distance[LANE_RIGHT]))
    else $error("state changed without a tick");

  // A held tick is not dropped while the result side is stalled.
  a_tick_kept: assert property (@(posedge clk) disable iff (rst)
    (stg_valid && !advance) |=> stg_valid)
    else $error("held tick lost");

endmodule
